// File: design/wavetable_tone_with_ramp_envelope_unit_assert.svh
// Assertion macros for the port checker of this block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef WAVETABLE_TONE_WITH_RAMP_ENVELOPE_UNIT_ASSERT_SVH
`define WAVETABLE_TONE_WITH_RAMP_ENVELOPE_UNIT_ASSERT_SVH

// same-cycle implication
`define WTRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WTRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wtre_pkg.sv
package wtre_pkg;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  // input transaction
  typedef struct packed {
    logic       kind;
    logic       gate;
    logic [7:0] table_addr;
    logic [7:0] table_data;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] dac_value;
    logic       idle_level;
  } out_t;

  // queued command
  typedef struct packed {
    cmd_e       op;
    logic       gate;
    logic [7:0] addr;
    logic [7:0] data;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT = 1'b1;

  localparam logic [7:0]  PHASE_STEP_RST = 8'd1;
  localparam logic [15:0] RAMP_LIMIT_RST = 16'd2205;

  localparam logic [7:0]         MIDSCALE = 8'd127;
  localparam logic signed [12:0] MID_X10  = 13'sd1270;

  // floor(v/10) == (v * RECIP10) >> RECIP10_SH for v below 2^16
  localparam logic [15:0] RECIP10    = 16'd52429;
  localparam int          RECIP10_SH = 19;

endpackage

// File: design/wtre_queue.sv
module wtre_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wtre_pkg::cmd_t        push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output wtre_pkg::cmd_slot_t   head_o
);

  wtre_pkg::cmd_t slot_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_ptr_q, rd_ptr_q;
  logic           do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: design/wtre_front.sv
module wtre_front #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wtre_pkg::in_t       in_data_i,
  input  logic                pop_i,
  output wtre_pkg::cmd_slot_t head_o
);

  localparam logic [12:0] DEPTH_X = 13'(TABLE_DEPTH);

  logic           full;
  logic           in_range;
  logic           push;
  wtre_pkg::cmd_t cmd;

  // table writes past the end are taken and dropped here
  assign in_range   = ({5'd0, in_data_i.table_addr} < DEPTH_X);
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full && !(in_data_i.kind && !in_range);

  always_comb begin
    cmd.op   = in_data_i.kind ? wtre_pkg::CMD_WRITE : wtre_pkg::CMD_TICK;
    cmd.gate = in_data_i.gate;
    cmd.addr = in_data_i.table_addr;
    cmd.data = in_data_i.table_data;
  end

  wtre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop_i),
    .head_o      (head_o)
  );

endmodule

// File: design/wtre_back.sv
module wtre_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wtre_pkg::cmd_slot_t head_i,
  output logic                pop_o,
  input  logic [7:0]          phase_step_i,
  input  logic [15:0]         ramp_limit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wtre_pkg::out_t      out_data_o
);

  localparam int PW   = $clog2(TABLE_DEPTH);
  localparam int XW   = (PW > 8) ? PW : 8;
  // shift-subtract steps to reduce phase + step below the depth
  localparam int KMAX = $clog2((2 * TABLE_DEPTH + 254) / TABLE_DEPTH) - 1;
  localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
  localparam int RW   = PW + KMAX + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PHASE = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_FIN1  = 4'd5;
  localparam logic [3:0] ST_FIN2  = 4'd6;
  localparam logic [3:0] ST_FIN3  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [1:0] TK_SILENT = 2'd0;
  localparam logic [1:0] TK_MID    = 2'd1;
  localparam logic [1:0] TK_WAVE   = 2'd2;

  logic [7:0]    mem [TABLE_DEPTH];
  logic [7:0]    rd_q;

  logic [3:0]    state_q, state_d;
  logic [PW-1:0] phase_q, phase_d;
  logic [15:0]   env_q, env_d;
  logic          muted_q, muted_d;
  logic          out_valid_q, out_valid_d;
  wtre_pkg::out_t out_data_q, out_data_d;

  logic [RW-1:0] rem_q, rem_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0]    class_q, class_d;
  logic          neg_q, neg_d;
  logic [23:0]   div_q, div_d;
  logic [15:0]   drem_q, drem_d;
  logic [4:0]    cnt_q, cnt_d;
  logic signed [12:0] v_q, v_d;
  logic [27:0]   p10_q, p10_d;
  wtre_pkg::out_t res_q, res_d;

  logic [15:0]   eff;
  logic          rise, fall;
  logic [15:0]   env_n;
  logic          muted_n;
  logic [XW-1:0] addr_x;
  logic [RW-1:0] shifted;
  logic [7:0]    mag;
  logic [16:0]   trial;
  logic [7:0]    m_sat;
  logic [10:0]   m7;
  logic [8:0]    q10;
  logic          wr_en;

  assign eff    = (ramp_limit_i == 16'd0) ? 16'd1 : ramp_limit_i;
  assign pop_o  = (state_q == ST_IDLE) && head_i.valid;
  assign wr_en  = pop_o && (head_i.cmd.op == wtre_pkg::CMD_WRITE);
  assign addr_x = XW'(head_i.cmd.addr);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // envelope ramp for the tick at the queue head
  assign rise  = head_i.cmd.gate && (env_q < eff);
  assign fall  = !head_i.cmd.gate && (env_q != 16'd0);
  assign env_n = rise ? env_q + 16'd1 : (fall ? env_q - 16'd1 : env_q);
  assign muted_n = rise ? 1'b0 : muted_q;

  assign shifted = RW'(TABLE_DEPTH) << k_q;
  assign mag     = (rd_q < wtre_pkg::MIDSCALE) ? wtre_pkg::MIDSCALE - rd_q
                                               : rd_q - wtre_pkg::MIDSCALE;
  assign trial   = {drem_q, div_q[23]};
  assign m_sat   = (|div_q[23:8]) ? 8'hFF : div_q[7:0];
  assign m7      = {m_sat, 3'b000} - {3'b000, m_sat};
  assign q10     = p10_q[27:wtre_pkg::RECIP10_SH];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    env_d       = env_q;
    muted_d     = muted_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rem_d       = rem_q;
    k_d         = k_q;
    class_d     = class_q;
    neg_d       = neg_q;
    div_d       = div_q;
    drem_d      = drem_q;
    cnt_d       = cnt_q;
    v_d         = v_q;
    p10_d       = p10_q;
    res_d       = res_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.cmd.op == wtre_pkg::CMD_TICK)) begin
          env_d = env_n;
          if (env_n == 16'd0) begin
            if (muted_n) begin
              class_d = TK_SILENT;
            end else begin
              class_d = TK_MID;
            end
            muted_d = 1'b1;
          end else begin
            class_d = TK_WAVE;
            muted_d = muted_n;
          end
          rem_d   = RW'(phase_q) + RW'(phase_step_i);
          k_d     = KW'(KMAX);
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (rem_q >= shifted) rem_d = rem_q - shifted;
        if (k_q == KW'(0)) begin
          phase_d = rem_d[PW-1:0];
          case (class_q)
            TK_SILENT: state_d = ST_IDLE;
            TK_MID: begin
              res_d.dac_value  = wtre_pkg::MIDSCALE;
              res_d.idle_level = 1'b1;
              state_d          = ST_OUT;
            end
            default: state_d = ST_READ;
          endcase
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        neg_d   = (rd_q < wtre_pkg::MIDSCALE);
        div_d   = 24'(mag) * 24'(env_q);
        drem_d  = 16'd0;
        cnt_d   = 5'd0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (trial >= {1'b0, eff}) begin
          drem_d = 16'(trial - {1'b0, eff});
          div_d  = {div_q[22:0], 1'b1};
        end else begin
          drem_d = trial[15:0];
          div_d  = {div_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd23) state_d = ST_FIN1;
      end
      ST_FIN1: begin
        v_d = neg_q ? wtre_pkg::MID_X10 - $signed({2'b00, m7})
                    : wtre_pkg::MID_X10 + $signed({2'b00, m7});
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        if (v_q < 0) begin
          p10_d = 28'd0;
        end else begin
          p10_d = 28'(v_q[11:0]) * 28'(wtre_pkg::RECIP10);
        end
        state_d = ST_FIN3;
      end
      ST_FIN3: begin
        res_d.dac_value  = (q10 > 9'd255) ? 8'hFF : q10[7:0];
        res_d.idle_level = 1'b0;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      env_q       <= 16'd0;
      muted_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      env_q       <= env_d;
      muted_q     <= muted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    rem_q      <= rem_d;
    k_q        <= k_d;
    class_q    <= class_d;
    neg_q      <= neg_d;
    div_q      <= div_d;
    drem_q     <= drem_d;
    cnt_q      <= cnt_d;
    v_q        <= v_d;
    p10_q      <= p10_d;
    res_q      <= res_d;
  end

  // waveform store: one write port, one registered read at the phase
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr_x[PW-1:0]] <= head_i.cmd.data;
    rd_q <= mem[phase_q];
  end

endmodule

// File: design/wavetable_tone_with_ramp_envelope_unit.sv
// Wavetable tone generator with a linear attack/release envelope.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction is either
// a table write (kind=1, loads table_data at table_addr; addresses at or past
// TABLE_DEPTH are dropped) or a sample tick (kind=0, gate selects attack or
// release). Only ticks produce output transactions, at most one each.
// Output channel (out_valid_o/out_ready_i/out_data_o): dac_value per tick;
// idle_level marks the single midscale result that enters mute.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 = phase_step, 1 = ramp_limit) at once; write only while idle.
// Structure: a front end classifies and queues transactions (2 entries), a
// back end executes one at a time. A table write is done at the pop; a tick
// reduces the phase (KMAX = 0 for TABLE_DEPTH >= 256); a silent tick ends
// there, a muting tick emits midscale, an audible tick reads the table and
// scales by a bit-serial divide by ramp_limit; the queue is registered.
// Reset (async, rst_ni low): phase, envelope and mute clear, config returns
// to phase_step=1, ramp_limit=2205; table contents are undefined.
// A stalled receiver holds the output register; the back end then waits
// with one finished result and the queue keeps taking input until full.
module wavetable_tone_with_ramp_envelope_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wtre_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output wtre_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [wtre_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wtre_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // config registers
  logic [7:0]  phase_step_q;
  logic [15:0] ramp_limit_q;

  // queue head between front and back end
  wtre_pkg::cmd_slot_t head;
  logic                pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= wtre_pkg::PHASE_STEP_RST;
      ramp_limit_q <= wtre_pkg::RAMP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wtre_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data_i[7:0];
        wtre_pkg::REG_RAMP_LIMIT: ramp_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front: accept, drop out-of-range writes, queue the rest
  wtre_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  // back: table store, phase/envelope update, scaling and output register
  wtre_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .phase_step_i (phase_step_q),
    .ramp_limit_i (ramp_limit_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: design/wtre_port_checker.sv
`include "wavetable_tone_with_ramp_envelope_unit_assert.svh"

module wtre_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input wtre_pkg::out_t out_data_i
);

  // idle flag of the last delivered transaction
  logic last_idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idle_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      last_idle_q <= out_data_i.idle_level;
    end
  end

  `WTRE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "output changed while stalled")

  `WTRE_ASSERT_IMP(a_idle_mid, out_valid_i && out_data_i.idle_level, out_data_i.dac_value == wtre_pkg::MIDSCALE, "idle result not at midscale")

  `WTRE_ASSERT_IMP(a_mute_once, out_valid_i && last_idle_q, !out_data_i.idle_level, "mute entered twice in a row")

  `WTRE_ASSERT_IMP(a_quiet_after_reset, !$past(rst_ni), !out_valid_i, "output valid right after reset")

endmodule

bind wavetable_tone_with_ramp_envelope_unit wtre_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// File: test/wavetable_tone_with_ramp_envelope_unit_tb.sv
module wavetable_tone_with_ramp_envelope_unit_tb;

  localparam int TBL_DEPTH   = 256;
  // watchdog bound, with a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // covers a 2-entry queue plus one tick in flight and one held result
  localparam int DRAIN_WAIT  = 150;
  localparam int HOLD_CYCLES = 400;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  wtre_pkg::in_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  wtre_pkg::out_t                  out_data_o;
  logic                            cfg_we_i;
  logic [wtre_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [wtre_pkg::CFG_DATA_W-1:0] cfg_data_i;

  wavetable_tone_with_ramp_envelope_unit #(
    .TABLE_DEPTH (TBL_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Tone predictor state: our own copy of config, phase, envelope, mute flag
  // and the waveform store. Updated when a transaction is accepted.
  // ---------------------------------------------------------------------------
  logic [7:0]  step_reg;
  logic [15:0] limit_reg;
  logic [7:0]  phase_q;
  logic [15:0] env_q;
  bit          muted_q;
  logic [7:0]  wave_mem [TBL_DEPTH];

  wtre_pkg::out_t dac_expected [$];     // predicted output transactions, oldest first
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   idle_off = 0;         // both sides run without gaps while set
  bit   hold_req = 0;         // asks the receiver for one long stall

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Envelope-scaled sample: trunc toward zero of (s-127)*env/limit, then
  // exact 7/10 scaling around midscale, clamped to 0..255.
  function automatic logic [7:0] scaled_level(logic [7:0] s);
    longint d, mag, q, v, lim;
    lim = (limit_reg == 16'd0) ? 1 : longint'(limit_reg);
    d   = longint'(s) - longint'(wtre_pkg::MIDSCALE);
    mag = (d < 0) ? -d : d;
    mag = mag * longint'(env_q) / lim;
    q   = (d < 0) ? -mag : mag;
    v   = longint'(wtre_pkg::MID_X10) + 7 * q;
    if (v < 0) return 8'd0;
    v = v / 10;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Applies one accepted transaction; returns 1 when it yields an output.
  function automatic bit tone_step(wtre_pkg::in_t it, output wtre_pkg::out_t res);
    longint lim;
    res = '0;
    if (it.kind == wtre_pkg::CMD_WRITE) begin
      if (it.table_addr < TBL_DEPTH) wave_mem[it.table_addr] = it.table_data;
      return 1'b0;
    end
    lim     = (limit_reg == 16'd0) ? 1 : longint'(limit_reg);
    phase_q = 8'((int'(phase_q) + int'(step_reg)) % TBL_DEPTH);
    // ramp only toward the limit; an envelope above a lowered limit holds
    if (it.gate && longint'(env_q) < lim) begin
      muted_q = 1'b0;
      env_q   = env_q + 16'd1;
    end else if (!it.gate && env_q > 16'd0) begin
      env_q = env_q - 16'd1;
    end
    if (env_q == 16'd0) begin
      if (muted_q) return 1'b0;         // already silent: nothing emitted
      muted_q        = 1'b1;            // one midscale write on entering mute
      res.dac_value  = wtre_pkg::MIDSCALE;
      res.idle_level = 1'b1;
      return 1'b1;
    end
    res.dac_value  = scaled_level(wave_mem[phase_q]);
    res.idle_level = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gap, then hold valid until the transaction is accepted.
  // Valid stays high on return so a gapless follow-up never toggles it.
  // ---------------------------------------------------------------------------
  task automatic send_item(wtre_pkg::in_t it);
    int             gap;
    wtre_pkg::out_t res;
    gap = idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (tone_step(it, res)) dac_expected.push_back(res);
  endtask

  task automatic send_tick(logic gate);
    wtre_pkg::in_t it;
    it.kind       = wtre_pkg::CMD_TICK;
    it.gate       = gate;
    it.table_addr = 8'($urandom);   // don't-care on ticks
    it.table_data = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_write(logic [7:0] addr, logic [7:0] data);
    wtre_pkg::in_t it;
    it.kind       = wtre_pkg::CMD_WRITE;
    it.gate       = 1'($urandom);   // don't-care on writes
    it.table_addr = addr;
    it.table_data = data;
    send_item(it);
  endtask

  // Drop valid, wait for every predicted result, then let trailing table
  // writes leave the queue before the block is treated as idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (dac_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Both registers, back to back; only called while the block is idle.
  task automatic write_settings(logic [7:0] step, logic [15:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= wtre_pkg::REG_PHASE_STEP;
    cfg_data_i  <= {8'($urandom), step};   // upper bits unused by phase_step
    @(posedge clk_i);
    cfg_index_i <= wtre_pkg::REG_RAMP_LIMIT;
    cfg_data_i  <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_reg  = step;
    limit_reg = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: per transaction a random stall, plus one long hold on request
  // so the queue fills and in_ready_o drops.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = idle_off ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Output checker: every accepted transaction against the oldest prediction.
  always @(posedge clk_i) begin
    wtre_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dac_expected.size() == 0) begin
        $display("%0t: unexpected output transaction dac_value=%0d idle_level=%0b",
                 $time, out_data_o.dac_value, out_data_o.idle_level);
        mismatch_count++;
      end else begin
        want = dac_expected.pop_front();
        if (out_data_o.dac_value !== want.dac_value) begin
          $display("%0t: dac_value mismatch expected=%0d actual=%0d",
                   $time, want.dac_value, out_data_o.dac_value);
          mismatch_count++;
        end
        if (out_data_o.idle_level !== want.idle_level) begin
          $display("%0t: idle_level mismatch expected=%0b actual=%0b",
                   $time, want.idle_level, out_data_o.idle_level);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every entry so no tick can ever read an unwritten sample.
  task automatic test_load_table();
    logic [7:0] data;
    for (int a = 0; a < TBL_DEPTH; a++) begin
      case (a)
        0:       data = 8'h00;
        1:       data = wtre_pkg::MIDSCALE;
        2:       data = 8'h80;
        255:     data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      send_write(8'(a), data);
    end
    settle();
  endtask

  // Attack to the limit, hold, release into mute, silent tick, leave mute.
  // Step 0 pins the phase so the sample under the cursor is known.
  task automatic test_envelope_cycle();
    write_settings(8'd0, 16'd3);
    send_write(phase_q, 8'hFF);
    repeat (4) send_tick(1'b1);   // 1,2,3 then held at the limit
    repeat (4) send_tick(1'b0);   // 2,1, midscale on reaching 0, then silent
    send_tick(1'b1);              // envelope rises: mute released
    settle();
  endtask

  // Envelope left above a lowered limit: no rise on gate, level clamps.
  task automatic test_saturation();
    write_settings(8'd0, 16'd4);
    repeat (4) send_tick(1'b1);
    settle();
    write_settings(8'd0, 16'd1);
    send_write(phase_q, 8'hFF);
    send_tick(1'b1);              // clamps high
    send_write(phase_q, 8'h00);
    send_tick(1'b1);              // clamps low
    send_tick(1'b0);              // falls, still above the limit
    settle();
  endtask

  // Zero limit acts as one; then the widest limit and step.
  task automatic test_zero_and_max_limit();
    write_settings(8'd255, 16'd0);
    repeat (3) send_tick(1'b0);   // down to zero, midscale once
    repeat (2) send_tick(1'b1);   // up to 1, then held
    settle();
    write_settings(8'd255, 16'hFFFF);
    repeat (2) send_tick(1'b1);
    settle();
  endtask

  // Mostly note-shaped gate runs, at small limits long enough to hit full scale
  // and silence, with random gate noise and table rewrites mixed in.
  task automatic test_random_notes(int n_phases);
    logic [7:0]  step;
    logic [15:0] lim;
    logic        gate;
    int          span, run;
    for (int p = 0; p < n_phases; p++) begin
      case ($urandom_range(0, 7))
        0:       step = 8'd0;
        1:       step = 8'd255;
        default: step = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       lim = 16'd0;
        1:       lim = 16'hFFFF;
        2:       lim = 16'($urandom_range(1, 65535));
        default: lim = 16'($urandom_range(1, 12));
      endcase
      write_settings(step, lim);
      idle_off = (p % 4 == 3);
      span = (lim == 16'd0) ? 1 : ((lim > 16'd20) ? 20 : int'(lim));
      gate = 1'($urandom);
      run  = $urandom_range(1, 2 * span + 2);
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_write(8'($urandom), 8'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          send_tick(1'($urandom));
        end else begin
          send_tick(gate);
          run--;
          if (run == 0) begin
            gate = !gate;
            run  = $urandom_range(1, 2 * span + 2);
          end
        end
      end
      settle();
      idle_off = 1'b0;
    end
  endtask

  // Receiver stalls for a long stretch while audible ticks keep coming.
  task automatic test_backpressure();
    write_settings(8'd1, 16'd2);
    idle_off = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_tick(1'b1);
    idle_off = 1'b0;
    settle();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= wtre_pkg::REG_PHASE_STEP;
    cfg_data_i  <= '0;
    step_reg  = wtre_pkg::PHASE_STEP_RST;
    limit_reg = wtre_pkg::RAMP_LIMIT_RST;
    phase_q   = 8'd0;
    env_q     = 16'd0;
    muted_q   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_load_table();
    test_envelope_cycle();
    test_saturation();
    test_zero_and_max_limit();
    test_random_notes(8);
    test_backpressure();
    settle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
